>>> sv/msfr_pkg.sv
package msfr_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 50;
  localparam int MOTOR_COUNT = 5;
  localparam int REC_BASE    = 4;
  localparam int REC_STRIDE  = 9;
  localparam int ID_SET_SIZE = 8;

  localparam int REC_END = REC_BASE + MOTOR_COUNT * REC_STRIDE;
  localparam int XMAX    = (FRAME_BYTES > REC_END) ? FRAME_BYTES : REC_END;

  // buffer ring and counter widths
  localparam int AW        = $clog2(FRAME_BYTES);
  localparam int BUF_DEPTH = 1 << AW;
  localparam int CW        = $clog2(FRAME_BYTES + 1);
  localparam int XW        = $clog2(XMAX + 1);
  localparam int OFF_W     = $clog2(REC_STRIDE);
  localparam int REC_W     = $clog2(MOTOR_COUNT + 1);

  // an id slot beyond the frame reads as zero, which is never a legal id
  localparam bit ID_BEYOND = (REC_BASE + (MOTOR_COUNT - 1) * REC_STRIDE) >= FRAME_BYTES;

  localparam int OUT_W = 8 + 32 + 32;

  localparam logic [7:0] ID_SET [ID_SET_SIZE] = '{8'd1, 8'd3, 8'd5, 8'd7,
                                                  8'd9, 8'd11, 8'd13, 8'd15};

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_HDR_FIRST  = 3'd0,
    CFG_HDR_SECOND = 3'd1,
    CFG_COMMAND    = 3'd2,
    CFG_SIDE_LEFT  = 3'd3,
    CFG_SIDE_RIGHT = 3'd4,
    CFG_OWN_SIDE   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic push;
    logic scan_go;
    logic check_go;
    logic emit_go;
  } msfr_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic cnt_pre_full;
    logic dirty;
    logic full;
    logic scan_done;
    logic check_done;
    logic good;
    logic own;
    logic emit_done;
  } msfr_stat_t;

  function automatic logic is_id_pos(input logic [XW-1:0] j);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      if (j == XW'(REC_BASE + k * REC_STRIDE)) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [MOTOR_COUNT-1:0] id_mask(input logic [7:0] d);
    logic [MOTOR_COUNT-1:0] m;
    m = '0;
    for (int s = 0; s < MOTOR_COUNT; s++) begin
      m[s] = (ID_SET[s] == d);
    end
    return m;
  endfunction

endpackage

>>> sv/msfr_ram.sv
module msfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/msfr_ctrl.sv
module msfr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  msfr_pkg::msfr_stat_t st,
  output msfr_pkg::msfr_cmd_t  cmd
);
  import msfr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CHECK, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   start_r;
  logic   fire;

  assign in_tready = (state_r == S_IDLE);
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          if (st.cnt_zero) state_nxt = S_IDLE;
          else if (st.cnt_one || st.dirty) state_nxt = S_SCAN;
          else if (st.cnt_pre_full) state_nxt = S_CHECK;
        end
      end
      S_SCAN: begin
        if (st.scan_done) state_nxt = st.full ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (st.check_done) begin
          if (!st.good) state_nxt = S_SCAN;
          else if (st.own) state_nxt = S_EMIT;
          else state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (st.emit_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_nxt != state_r) && (state_nxt != S_IDLE);
    end
  end

  assign cmd.push     = fire;
  assign cmd.scan_go  = start_r && (state_r == S_SCAN);
  assign cmd.check_go = start_r && (state_r == S_CHECK);
  assign cmd.emit_go  = start_r && (state_r == S_EMIT);

endmodule

>>> sv/msfr_dp.sv
module msfr_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  msfr_pkg::msfr_cmd_t        cmd,
  output msfr_pkg::msfr_stat_t       st,
  input  logic [7:0]                 in_byte,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_addr,
  input  logic [7:0]                 cfg_wdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [msfr_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import msfr_pkg::*;

  typedef enum logic [1:0] {PH_NONE, PH_SCAN, PH_CHECK, PH_EMIT} phase_t;

  // configuration
  logic [7:0] hdr1_r, hdr2_r, cmd_code_r, side_l_r, side_r_r, own_code_r;

  // buffer ring
  logic [AW-1:0] head_r;
  logic [CW-1:0] cnt_r;
  logic          dirty_r;

  // walker
  phase_t        phase_r;
  logic          act_r;
  logic [XW-1:0] idx_r;
  logic          rd_v_r;
  logic [XW-1:0] rd_idx_r;
  logic [7:0]    ram_q;
  logic [7:0]    d;

  // scan and check
  logic [7:0]             prev_r;
  logic [7:0]             sum_r;
  logic                   ok_r;
  logic [MOTOR_COUNT-1:0] seen_r;
  logic [7:0]             side_byte_r;
  logic                   scan_done_r, check_done_r, good_r, own_r, emit_done_r;

  // record assembly and output register
  logic [OFF_W-1:0] iss_off_r, rcv_off_r;
  logic [REC_W-1:0] rcv_rec_r;
  logic [7:0]       asm_id_r;
  logic [31:0]      asm_pos_r, asm_vel_r;
  logic             asm_full_r;
  logic [7:0]       out_id_r;
  logic [31:0]      out_pos_r, out_vel_r;
  logic             out_last_r, out_valid_r;

  logic [XW-1:0]          cnt_x;
  logic [XW-1:0]          p;
  logic                   found;
  logic [MOTOR_COUNT-1:0] mask;
  logic                   chk_ok, ok_nxt;
  logic                   xfer, last_rec;
  logic                   last_issue;

  msfr_ram #(.Width(8), .Depth(BUF_DEPTH)) u_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(head_r + cnt_r[AW-1:0]),
    .wdata(in_byte),
    .raddr(head_r + idx_r[AW-1:0]),
    .rdata(ram_q)
  );

  assign d     = (rd_idx_r >= XW'(FRAME_BYTES)) ? 8'd0 : ram_q;
  assign cnt_x = XW'(cnt_r);
  assign p     = rd_idx_r - XW'(1);
  assign found = (rd_idx_r != '0) && (prev_r == hdr1_r) && (d == hdr2_r);
  assign mask  = id_mask(d);

  always_comb begin
    chk_ok = 1'b1;
    if (rd_idx_r == XW'(0)) chk_ok = (d == hdr1_r);
    if (rd_idx_r == XW'(1)) chk_ok = (d == hdr2_r);
    if (rd_idx_r == XW'(2)) chk_ok = (d == cmd_code_r);
    if (rd_idx_r == XW'(3)) chk_ok = (d == side_l_r) || (d == side_r_r);
    if (is_id_pos(rd_idx_r)) chk_ok = (|mask) && !(|(mask & seen_r));
    if (rd_idx_r == XW'(FRAME_BYTES - 1)) chk_ok = (sum_r == d);
  end
  assign ok_nxt = ok_r && chk_ok;

  always_comb begin
    case (phase_r)
      PH_SCAN:  last_issue = (idx_r == cnt_x - XW'(1));
      PH_CHECK: last_issue = (idx_r == XW'(FRAME_BYTES - 1));
      PH_EMIT:  last_issue = (iss_off_r == OFF_W'(REC_STRIDE - 1));
      default:  last_issue = 1'b1;
    endcase
  end

  assign last_rec = (rcv_rec_r == REC_W'(MOTOR_COUNT - 1));
  assign xfer     = asm_full_r && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr1_r       <= 8'd0;
      hdr2_r       <= 8'd0;
      cmd_code_r   <= 8'd0;
      side_l_r     <= 8'd0;
      side_r_r     <= 8'd1;
      own_code_r   <= 8'd0;
      head_r       <= '0;
      cnt_r        <= '0;
      dirty_r      <= 1'b0;
      phase_r      <= PH_NONE;
      act_r        <= 1'b0;
      rd_v_r       <= 1'b0;
      scan_done_r  <= 1'b0;
      check_done_r <= 1'b0;
      emit_done_r  <= 1'b0;
      asm_full_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      scan_done_r  <= 1'b0;
      check_done_r <= 1'b0;
      emit_done_r  <= 1'b0;
      rd_v_r       <= act_r;
      rd_idx_r     <= idx_r;

      if (cfg_we) begin
        case (cfg_addr)
          CFG_HDR_FIRST: begin
            hdr1_r  <= cfg_wdata;
            dirty_r <= 1'b1;
          end
          CFG_HDR_SECOND: begin
            hdr2_r  <= cfg_wdata;
            dirty_r <= 1'b1;
          end
          CFG_COMMAND:    cmd_code_r <= cfg_wdata;
          CFG_SIDE_LEFT:  side_l_r   <= cfg_wdata;
          CFG_SIDE_RIGHT: side_r_r   <= cfg_wdata;
          CFG_OWN_SIDE:   own_code_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.push) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == '0) dirty_r <= 1'b0;
      end

      if (cmd.scan_go) begin
        phase_r <= PH_SCAN;
        act_r   <= 1'b1;
        idx_r   <= '0;
        dirty_r <= 1'b0;
      end
      if (cmd.check_go) begin
        phase_r <= PH_CHECK;
        act_r   <= 1'b1;
        idx_r   <= '0;
        ok_r    <= !ID_BEYOND;
        sum_r   <= 8'd0;
        seen_r  <= '0;
      end
      if (cmd.emit_go) begin
        phase_r    <= PH_EMIT;
        act_r      <= 1'b1;
        idx_r      <= XW'(REC_BASE);
        iss_off_r  <= '0;
        rcv_off_r  <= '0;
        rcv_rec_r  <= '0;
        asm_full_r <= 1'b0;
      end

      // read issue
      if (act_r && phase_r != PH_NONE) begin
        idx_r <= idx_r + XW'(1);
        if (phase_r == PH_EMIT) begin
          iss_off_r <= last_issue ? '0 : iss_off_r + OFF_W'(1);
        end
        if (last_issue) act_r <= 1'b0;
      end

      // returned read data
      if (rd_v_r) begin
        case (phase_r)
          PH_SCAN: begin
            prev_r <= d;
            if (found) begin
              head_r      <= head_r + p[AW-1:0];
              cnt_r       <= cnt_r - CW'(p);
              phase_r     <= PH_NONE;
              act_r       <= 1'b0;
              scan_done_r <= 1'b1;
            end else if (rd_idx_r == cnt_x - XW'(1)) begin
              head_r      <= head_r + AW'(cnt_r - CW'(1));
              cnt_r       <= CW'(1);
              phase_r     <= PH_NONE;
              act_r       <= 1'b0;
              scan_done_r <= 1'b1;
            end
          end
          PH_CHECK: begin
            ok_r <= ok_nxt;
            if (rd_idx_r == XW'(3)) side_byte_r <= d;
            if (rd_idx_r >= XW'(2) && rd_idx_r <= XW'(FRAME_BYTES - 2)) sum_r <= sum_r + d;
            if (is_id_pos(rd_idx_r)) seen_r <= seen_r | mask;
            if (rd_idx_r == XW'(FRAME_BYTES - 1)) begin
              check_done_r <= 1'b1;
              good_r       <= ok_nxt;
              own_r        <= (side_byte_r == own_code_r);
              phase_r      <= PH_NONE;
              if (ok_nxt) begin
                cnt_r <= '0;
              end else begin
                head_r <= head_r + AW'(1);
                cnt_r  <= cnt_r - CW'(1);
              end
            end
          end
          PH_EMIT: begin
            if (rcv_off_r == '0) asm_id_r <= d;
            else if (rcv_off_r <= OFF_W'(4)) asm_pos_r <= {d, asm_pos_r[31:8]};
            else asm_vel_r <= {d, asm_vel_r[31:8]};
            if (rcv_off_r == OFF_W'(REC_STRIDE - 1)) begin
              rcv_off_r  <= '0;
              asm_full_r <= 1'b1;
            end else begin
              rcv_off_r <= rcv_off_r + OFF_W'(1);
            end
          end
          default: ;
        endcase
      end

      // hand a finished record to the output register
      if (xfer) begin
        out_id_r    <= asm_id_r;
        out_pos_r   <= asm_pos_r;
        out_vel_r   <= asm_vel_r;
        out_last_r  <= last_rec;
        out_valid_r <= 1'b1;
        asm_full_r  <= 1'b0;
        if (last_rec) begin
          emit_done_r <= 1'b1;
          phase_r     <= PH_NONE;
          rcv_rec_r   <= '0;
        end else begin
          rcv_rec_r <= rcv_rec_r + REC_W'(1);
          act_r     <= 1'b1;
        end
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign st.cnt_zero     = (cnt_r == '0);
  assign st.cnt_one      = (cnt_r == CW'(1));
  assign st.cnt_pre_full = (cnt_r == CW'(FRAME_BYTES - 1));
  assign st.full         = (cnt_r == CW'(FRAME_BYTES));
  assign st.dirty        = dirty_r;
  assign st.scan_done    = scan_done_r;
  assign st.check_done   = check_done_r;
  assign st.good         = good_r;
  assign st.own          = own_r;
  assign st.emit_done    = emit_done_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_vel_r, out_pos_r, out_id_r};
  assign out_tlast  = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FRAME_BYTES))
    else $error("buffer count past frame length");

  a_good_consumes: assert property (@(posedge clk) disable iff (!rst_n)
    check_done_r && good_r |-> cnt_r == '0)
    else $error("good frame not consumed");

  a_scan_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done_r |-> cnt_r != '0)
    else $error("scan emptied the buffer");

endmodule

>>> sv/motor_state_frame_receiver_top.sv
// channel | beat contents (lsb first)                          | accepted when
// in      | in_tdata: data_byte[7:0]                           | in_tvalid & in_tready
// out     | out_tdata: motor_id, position_bits, velocity_bits; | out_tvalid & out_tready
//         | out_tlast: last_record                             |
// cfg     | cfg_addr register index, cfg_wdata value           | cfg_we
//
// a byte that only extends a buffered frame leaves the receiver idle and ready; the second
// byte after an empty buffer, or a byte after a header register write into a non-empty buffer,
// runs a rescan of the ring buffer at one byte per cycle, bounded by the single ram read port
// a completed frame adds a check pass over FRAME_BYTES bytes, a failed check adds a rescan,
// and an own-side frame emits its records one at a time, each leaving on an out handshake
// reset is synchronous, active low; it empties the buffer and loads the register defaults
// a stalled out_tready holds the output register and the emit; no input is taken until emit ends
module motor_state_frame_receiver_top
  import msfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // data_byte[7:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // motor_id[7:0], position_bits[39:8], velocity_bits[71:40]
  output logic             out_tlast,  // last_record
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [7:0]       cfg_wdata
);

  msfr_cmd_t  cmd;
  msfr_stat_t st;

  // sequencing: idle, rescan, frame check, record emit
  msfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // ring buffer, scanner, checker and record assembly
  msfr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_byte   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
